// ===== hw/rtl/gha_pkg.sv =====
// shared types, codes and bit helpers for the generational handle allocator
package gha_pkg;

    localparam int WORD_BITS = 32;
    localparam int WB_W      = 5;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WB_W-1:0]      bitpos_t;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_STALE = 2'd2;

    // command to the shared bitmap word unit
    typedef struct packed {
        logic    limit_en;
        bitpos_t limit;
        bitpos_t pos;
        logic    set_bit;
        logic    clr_bit;
        logic    clr_top;
    } word_cmd_t;

    typedef struct packed {
        logic    any;
        bitpos_t top;
        word_t   word;
        logic    any_after;
        logic    bit_val;
    } word_res_t;

    function automatic bitpos_t highest_bit(word_t w);
        bitpos_t r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (w[i])
            begin
                r = bitpos_t'(i);
            end
        end
        return r;
    endfunction

    // ones at and below bit k
    function automatic word_t mask_upto(bitpos_t k);
        return word_t'({WORD_BITS{1'b1}}) >> (bitpos_t'(WORD_BITS - 1) - k);
    endfunction

    function automatic word_t onehot(bitpos_t p);
        return word_t'(1) << p;
    endfunction

    function automatic word_t put_bit(word_t w, bitpos_t p, logic v);
        return (w & ~onehot(p)) | (word_t'(v) << p);
    endfunction

endpackage

// ===== hw/rtl/gha_word_unit.sv =====
// shared bitmap word unit: highest set bit search under a limit, bit set and clear
module gha_word_unit
    import gha_pkg::*;
(
    input  word_t     data,
    input  word_cmd_t cmd,
    output word_res_t res
);

    word_t   lim;
    word_t   masked;
    bitpos_t top;
    word_t   nw;

    always_comb
    begin
        lim    = cmd.limit_en ? mask_upto(cmd.limit) : '1;
        masked = data & lim;
        top    = highest_bit(masked);
        priority if (cmd.set_bit)
        begin
            nw = data | onehot(cmd.pos);
        end
        else if (cmd.clr_bit)
        begin
            nw = data & ~onehot(cmd.pos);
        end
        else if (cmd.clr_top)
        begin
            nw = data & ~onehot(top);
        end
        else
        begin
            nw = data;
        end
        res.any       = |masked;
        res.top       = top;
        res.word      = nw;
        res.any_after = |(nw & lim);
        res.bit_val   = data[cmd.pos];
    end

endmodule

// ===== hw/rtl/generational_handle_allocator_core.sv =====
// generational handle allocator: slot versions, free bitmap with summary, sequencer
//
// Allocate, destroy and check one handle at a time. A handle is an index and a
// version; destroy bumps the slot's version and frees it, allocate reuses the
// highest freed index (version kept) or else takes the next fresh index at
// version 0. Free slots are kept as a bitmap of 32-bit words plus one summary
// bit per word, and a single word unit walks summary then word to find the
// highest free slot, reading summary words, each covering 1024 slots, from the top
// down. A result sits in an output register, so the next transaction may be
// accepted while it waits. The high-water count bounds every read, so no
// clearing pass follows reset.
module generational_handle_allocator_core
    import gha_pkg::*;
#(
    parameter int MAX_SLOTS    = 1024,
    parameter int VERSION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [9:0]  slot_index,
    input  logic [15:0] slot_version,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  handle_index,
    output logic [15:0] handle_version,
    output logic        handle_live
);

    localparam int IDX_W   = $clog2(MAX_SLOTS);
    localparam int MARK_W  = $clog2(MAX_SLOTS + 1);
    localparam int NWORDS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int NCHUNKS = (NWORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CA_W    = (NCHUNKS > 1) ? $clog2(NCHUNKS) : 1;
    localparam int SN_W    = (MARK_W > 2 * WB_W + CA_W) ? MARK_W : 2 * WB_W + CA_W;
    localparam int WN_W    = SN_W - WB_W;
    localparam int CMP_W   = (VERSION_BITS > 16) ? VERSION_BITS : 16;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_PICK   = 3'd2;
    localparam logic [2:0] ST_VER    = 3'd3;
    localparam logic [2:0] ST_FRESH  = 3'd4;
    localparam logic [2:0] ST_HANDLE = 3'd5;

    typedef logic [SN_W-1:0]         sn_t;
    typedef logic [WN_W-1:0]         wn_t;
    typedef logic [CA_W-1:0]         ca_t;
    typedef logic [VERSION_BITS-1:0] ver_t;

    function automatic wn_t word_of(sn_t s);
        return wn_t'(s >> WB_W);
    endfunction

    function automatic ca_t chunk_of(wn_t w);
        return ca_t'(w >> WB_W);
    endfunction

    function automatic bitpos_t wpos_of(wn_t w);
        return w[WB_W-1:0];
    endfunction

    // memories
    ver_t  ver_mem [MAX_SLOTS];
    word_t map_mem [NWORDS];
    word_t sum_mem [NCHUNKS];

    ver_t  ver_q;
    word_t map_q;
    word_t sum_q;

    logic [IDX_W-1:0] ver_raddr;
    logic [IDX_W-1:0] ver_waddr;
    ver_t             ver_wdata;
    logic             ver_we;
    logic [WA_W-1:0]  map_raddr;
    logic [WA_W-1:0]  map_waddr;
    word_t            map_wdata;
    logic             map_we;
    ca_t              sum_raddr;
    ca_t              sum_waddr;
    word_t            sum_wdata;
    logic             sum_we;

    // sequencer and output registers
    logic [2:0]        state_reg, state_next;
    logic [MARK_W-1:0] mark_reg, mark_next;
    logic [1:0]        op_reg, op_next;
    logic [9:0]        idx_reg, idx_next;
    logic [15:0]       ver_reg, ver_next;
    logic              in_range_reg, in_range_next;
    ca_t               chunk_reg, chunk_next;
    word_t             chunk_data_reg, chunk_data_next;
    wn_t               word_reg, word_next;
    sn_t               slot_reg, slot_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [9:0]        out_idx_reg, out_idx_next;
    logic [15:0]       out_ver_reg, out_ver_next;
    logic              out_live_reg, out_live_next;

    word_t     unit_data;
    word_cmd_t unit_cmd;
    word_res_t unit_res;

    sn_t  mark_sn;
    sn_t  top_sn;
    wn_t  top_wn;
    ca_t  top_ch;
    wn_t  mark_wn;
    sn_t  in_sn;
    sn_t  idx_sn;
    sn_t  pick_sn;
    logic out_free;
    logic out_load;
    logic live;

    assign mark_sn  = sn_t'(mark_reg);
    assign top_sn   = mark_sn - sn_t'(1);
    assign top_wn   = word_of(top_sn);
    assign top_ch   = chunk_of(top_wn);
    assign mark_wn  = word_of(mark_sn);
    assign in_sn    = sn_t'(slot_index);
    assign idx_sn   = sn_t'(idx_reg);
    assign pick_sn  = sn_t'({word_reg, unit_res.top});
    assign out_free = !out_valid_reg || out_ready;
    assign live     = in_range_reg && !unit_res.bit_val &&
                      (CMP_W'(ver_q) == CMP_W'(ver_reg));

    gha_word_unit u_word_unit
    (
        .data (unit_data),
        .cmd  (unit_cmd),
        .res  (unit_res)
    );

    // what the shared unit does in each step
    always_comb
    begin
        unit_data = map_q;
        unit_cmd  = '0;
        unique case (state_reg)
            ST_SCAN:
            begin
                unit_data         = sum_q;
                unit_cmd.limit_en = (chunk_reg == top_ch);
                unit_cmd.limit    = wpos_of(top_wn);
            end
            ST_PICK:
            begin
                unit_cmd.limit_en = (word_reg == top_wn);
                unit_cmd.limit    = top_sn[WB_W-1:0];
                unit_cmd.clr_top  = 1'b1;
            end
            ST_FRESH:
            begin
                unit_cmd.limit_en = 1'b1;
                unit_cmd.limit    = mark_sn[WB_W-1:0];
                unit_cmd.pos      = mark_sn[WB_W-1:0];
                unit_cmd.clr_bit  = 1'b1;
            end
            ST_HANDLE:
            begin
                unit_cmd.pos     = idx_reg[WB_W-1:0];
                unit_cmd.set_bit = 1'b1;
            end
            default:
            begin
                unit_cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        mark_next       = mark_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        ver_next        = ver_reg;
        in_range_next   = in_range_reg;
        chunk_next      = chunk_reg;
        chunk_data_next = chunk_data_reg;
        word_next       = word_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        out_idx_next    = out_idx_reg;
        out_ver_next    = out_ver_reg;
        out_live_next   = out_live_reg;
        out_load        = 1'b0;

        ver_raddr = IDX_W'(idx_sn);
        map_raddr = WA_W'(word_of(idx_sn));
        sum_raddr = chunk_of(word_of(idx_sn));
        ver_we    = 1'b0;
        ver_waddr = IDX_W'(idx_sn);
        ver_wdata = ver_q + ver_t'(1);
        map_we    = 1'b0;
        map_waddr = WA_W'(word_of(idx_sn));
        map_wdata = unit_res.word;
        sum_we    = 1'b0;
        sum_waddr = chunk_of(word_of(idx_sn));
        sum_wdata = put_bit(sum_q, wpos_of(word_of(idx_sn)), 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                ver_raddr = IDX_W'(in_sn);
                if (operation == OP_ALLOC)
                begin
                    map_raddr = WA_W'(mark_wn);
                    sum_raddr = (mark_reg == '0) ? chunk_of(mark_wn) : top_ch;
                end
                else
                begin
                    map_raddr = WA_W'(word_of(in_sn));
                    sum_raddr = chunk_of(word_of(in_sn));
                end
                if (in_valid)
                begin
                    op_next       = operation;
                    idx_next      = slot_index;
                    ver_next      = slot_version;
                    in_range_next = (in_sn < mark_sn);
                    chunk_next    = top_ch;
                    if (operation != OP_ALLOC)
                    begin
                        state_next = ST_HANDLE;
                    end
                    else if (mark_reg == '0)
                    begin
                        state_next = ST_FRESH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // walk the summary from the top word downwards
                priority if (unit_res.any)
                begin
                    word_next       = wn_t'({chunk_reg, unit_res.top});
                    map_raddr       = WA_W'(wn_t'({chunk_reg, unit_res.top}));
                    chunk_data_next = sum_q;
                    state_next      = ST_PICK;
                end
                else if (chunk_reg == '0)
                begin
                    map_raddr  = WA_W'(mark_wn);
                    sum_raddr  = chunk_of(mark_wn);
                    state_next = ST_FRESH;
                end
                else
                begin
                    chunk_next = chunk_reg - ca_t'(1);
                    sum_raddr  = chunk_reg - ca_t'(1);
                end
            end
            ST_PICK:
            begin
                slot_next  = pick_sn;
                ver_raddr  = IDX_W'(pick_sn);
                map_we     = 1'b1;
                map_waddr  = WA_W'(word_reg);
                sum_we     = 1'b1;
                sum_waddr  = chunk_reg;
                sum_wdata  = put_bit(chunk_data_reg, wpos_of(word_reg), unit_res.any_after);
                state_next = ST_VER;
            end
            ST_VER:
            begin
                ver_raddr = IDX_W'(slot_reg);
                if (out_free)
                begin
                    out_load      = 1'b1;
                    status_next   = STATUS_OK;
                    out_idx_next  = 10'(slot_reg);
                    out_ver_next  = 16'(ver_q);
                    out_live_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FRESH:
            begin
                map_raddr = WA_W'(mark_wn);
                sum_raddr = chunk_of(mark_wn);
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (mark_reg == MARK_W'(MAX_SLOTS))
                    begin
                        status_next   = STATUS_FULL;
                        out_idx_next  = '0;
                        out_ver_next  = '0;
                        out_live_next = 1'b0;
                    end
                    else
                    begin
                        ver_we        = 1'b1;
                        ver_waddr     = IDX_W'(mark_sn);
                        ver_wdata     = '0;
                        map_we        = 1'b1;
                        map_waddr     = WA_W'(mark_wn);
                        sum_we        = 1'b1;
                        sum_waddr     = chunk_of(mark_wn);
                        sum_wdata     = put_bit(sum_q, wpos_of(mark_wn), unit_res.any_after);
                        mark_next     = mark_reg + MARK_W'(1);
                        status_next   = STATUS_OK;
                        out_idx_next  = 10'(mark_sn);
                        out_ver_next  = '0;
                        out_live_next = 1'b1;
                    end
                end
            end
            ST_HANDLE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    state_next    = ST_IDLE;
                    status_next   = live ? STATUS_OK : STATUS_STALE;
                    out_idx_next  = idx_reg;
                    out_ver_next  = ver_reg;
                    out_live_next = live && (op_reg != OP_DESTROY);
                    // destroy of a live handle: bump version, mark free
                    if (live && (op_reg == OP_DESTROY))
                    begin
                        ver_we = 1'b1;
                        map_we = 1'b1;
                        sum_we = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ver_we)
        begin
            ver_mem[ver_waddr] <= ver_wdata;
        end
        ver_q <= ver_mem[ver_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_q <= sum_mem[sum_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        ver_reg        <= ver_next;
        in_range_reg   <= in_range_next;
        chunk_reg      <= chunk_next;
        chunk_data_reg <= chunk_data_next;
        word_reg       <= word_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        out_idx_reg    <= out_idx_next;
        out_ver_reg    <= out_ver_next;
        out_live_reg   <= out_live_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign handle_index   = out_idx_reg;
    assign handle_version = out_ver_reg;
    assign handle_live    = out_live_reg;

endmodule

// ===== bench/tb.sv =====
// testbench for the generational handle allocator core: directed, reuse, random and fill tests
module tb
    import gha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT = 1024;
    localparam int LONG_HOLD  = 120;
    localparam logic [1:0] OP_CHECK = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  idx;
        logic [15:0] ver;
        logic        live;
    } handle_result_t;

    typedef struct packed {
        logic [9:0]  idx;
        logic [15:0] ver;
    } handle_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = OP_ALLOC;
    logic [9:0]  slot_index = '0;
    logic [15:0] slot_version = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [9:0]  handle_index;
    logic [15:0] handle_version;
    logic        handle_live;

    // predicted allocator state
    logic [15:0] slot_gen [SLOT_COUNT];
    bit          slot_freed [SLOT_COUNT];
    int unsigned high_mark = 0;
    int          free_count = 0;

    handle_result_t pending_results [$];
    handle_result_t last_result;
    handle_t        live_handles [$];
    handle_t        dead_handles [$];

    int error_count = 0;
    int burst_left = 0;
    bit idle_on = 1'b1;
    bit stall_on = 1'b1;
    int hold_asked = 0;
    int hold_served = 0;

    generational_handle_allocator_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .slot_index     (slot_index),
        .slot_version   (slot_version),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .handle_index   (handle_index),
        .handle_version (handle_version),
        .handle_live    (handle_live)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic handle_result_t predict_handle_op(input logic [1:0] op,
                                                         input logic [9:0] idx,
                                                         input logic [15:0] ver);
        handle_result_t r;
        int  slot;
        bit  found;
        bit  live_hit;
        r.status = STATUS_OK;
        r.idx    = idx;
        r.ver    = ver;
        r.live   = 1'b0;
        live_hit = (idx < high_mark) && !slot_freed[idx] && (slot_gen[idx] == ver);
        if (op == OP_ALLOC)
        begin
            // highest freed slot wins, else a fresh one at version zero
            found = 1'b0;
            slot  = int'(high_mark);
            while (slot > 0 && !found)
            begin
                slot--;
                found = slot_freed[slot];
            end
            if (found)
            begin
                slot_freed[slot] = 1'b0;
                free_count--;
                r.idx  = slot[9:0];
                r.ver  = slot_gen[slot];
                r.live = 1'b1;
            end
            else if (high_mark < SLOT_COUNT)
            begin
                r.idx = high_mark[9:0];
                slot_gen[high_mark] = '0;
                high_mark++;
                r.ver  = '0;
                r.live = 1'b1;
            end
            else
            begin
                r.status = STATUS_FULL;
                r.idx    = '0;
                r.ver    = '0;
            end
        end
        else if (op == OP_DESTROY)
        begin
            if (live_hit)
            begin
                slot_gen[idx]   = ver + 16'd1;
                slot_freed[idx] = 1'b1;
                free_count++;
            end
            else
            begin
                r.status = STATUS_STALE;
            end
        end
        else
        begin
            if (live_hit)
                r.live = 1'b1;
            else
                r.status = STATUS_STALE;
        end
        return r;
    endfunction

    // predicts, queues the expectation, then offers one transaction until taken
    task automatic issue_op(input logic [1:0] op, input logic [9:0] idx,
                            input logic [15:0] ver);
        int gap;
        int pos;
        last_result = predict_handle_op(op, idx, ver);
        pending_results.insert(pending_results.size(), last_result);
        if (op == OP_ALLOC && last_result.status == STATUS_OK)
        begin
            live_handles.insert(live_handles.size(),
                                handle_t'({last_result.idx, last_result.ver}));
        end
        else if (op == OP_DESTROY && last_result.status == STATUS_OK)
        begin
            pos = -1;
            foreach (live_handles[i])
            begin
                if (live_handles[i].idx == idx && live_handles[i].ver == ver)
                    pos = i;
            end
            if (pos >= 0)
                live_handles.delete(pos);
            dead_handles.insert(dead_handles.size(), handle_t'({idx, ver}));
            if (dead_handles.size() > 64)
                void'(dead_handles.pop_front());
        end
        if (idle_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        operation    <= op;
        slot_index   <= idx;
        slot_version <= ver;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    function automatic handle_t pick_live();
        return live_handles[$urandom_range(0, live_handles.size() - 1)];
    endfunction

    // result checker
    always @(posedge clk)
    begin
        handle_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d index %0d version %0d live %0d",
                       status, handle_index, handle_version, handle_live);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, status);
                    error_count++;
                end
                if (handle_index !== exp_res.idx)
                begin
                    $error("handle_index: expected %0d, actual %0d", exp_res.idx, handle_index);
                    error_count++;
                end
                if (handle_version !== exp_res.ver)
                begin
                    $error("handle_version: expected %0d, actual %0d",
                           exp_res.ver, handle_version);
                    error_count++;
                end
                if (handle_live !== exp_res.live)
                begin
                    $error("handle_live: expected %0d, actual %0d", exp_res.live, handle_live);
                    error_count++;
                end
            end
        end
    end

    // receiver: stall patterns that change now and then, plus long hold-offs on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!stall_on)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic test_directed_cases();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        issue_op(OP_ALLOC, '1, '1);
        issue_op(OP_ALLOC, '0, '0);
        issue_op(OP_ALLOC, 10'd7, 16'd9);
        issue_op(OP_CHECK, 10'd1, 16'd0);
        issue_op(OP_CHECK, 10'd1, 16'd5);
        issue_op(OP_CHECK, 10'h3FF, 16'hFFFF);
        // index equal to the high-water count
        issue_op(OP_CHECK, 10'd3, 16'd0);
        issue_op(OP_DESTROY, 10'd1, 16'd0);
        issue_op(OP_DESTROY, 10'd1, 16'd0);
        // freed slot whose stored version matches
        issue_op(OP_CHECK, 10'd1, 16'd1);
        issue_op(OP_SPARE, 10'd0, 16'd0);
        issue_op(OP_SPARE, 10'h3FF, 16'hFFFF);
        issue_op(OP_DESTROY, 10'd2, 16'd0);
        issue_op(OP_DESTROY, 10'd0, 16'hFFFF);
        issue_op(OP_ALLOC, '0, '0);
        issue_op(OP_ALLOC, '0, '0);
        issue_op(OP_ALLOC, '0, '0);
        issue_op(OP_CHECK, 10'd2, 16'd1);
        issue_op(OP_CHECK, 10'd2, 16'd0);
        issue_op(OP_DESTROY, 10'd3, 16'd0);
        issue_op(OP_DESTROY, 10'd2, 16'd1);
        issue_op(OP_ALLOC, '0, '0);
        issue_op(OP_ALLOC, '1, '1);
        wait_results_drained();
    endtask

    // one slot cycled through destroy and reallocate, its version climbing each time
    task automatic test_slot_reuse();
        handle_t h;
        idle_on  = 1'b0;
        stall_on = 1'b0;
        issue_op(OP_ALLOC, '0, '0);
        h = {last_result.idx, last_result.ver};
        repeat (24)
        begin
            issue_op(OP_DESTROY, h.idx, h.ver);
            issue_op(OP_ALLOC, '0, '0);
            h = {last_result.idx, last_result.ver};
        end
        issue_op(OP_CHECK, h.idx, h.ver);
        issue_op(OP_CHECK, h.idx, 16'hFFFF);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int          r;
        handle_t     h;
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [15:0] ver;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 3)
                hold_asked++;
            if (n == (2 * count) / 3)
                wait_results_drained();
            r   = $urandom_range(0, 99);
            op  = OP_ALLOC;
            idx = 10'($urandom);
            ver = 16'($urandom);
            if (r >= 85)
            begin
                op = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1)
                    idx = 10'($urandom_range(0, high_mark));
                if ($urandom_range(0, 1) == 1)
                    ver = 16'($urandom_range(0, 3));
            end
            else if (live_handles.size() == 0 || (r < 30 && live_handles.size() <= 48))
            begin
                op = OP_ALLOC;
            end
            else if (r < 55)
            begin
                h   = pick_live();
                op  = OP_DESTROY;
                idx = h.idx;
                ver = h.ver;
            end
            else if (r < 75)
            begin
                h   = pick_live();
                op  = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_CHECK;
                idx = h.idx;
                ver = h.ver;
            end
            else
            begin
                // stale handles: an old generation or a bumped version
                if (dead_handles.size() > 0 && $urandom_range(0, 1) == 1)
                begin
                    h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
                end
                else
                begin
                    h = pick_live();
                    h.ver = h.ver + 16'd1;
                end
                op  = ($urandom_range(0, 1) == 1) ? OP_DESTROY : OP_CHECK;
                idx = h.idx;
                ver = h.ver;
            end
            issue_op(op, idx, ver);
        end
        wait_results_drained();
    endtask

    task automatic test_fill_to_full();
        handle_t h;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        while (high_mark < SLOT_COUNT || free_count > 0)
            issue_op(OP_ALLOC, 10'($urandom), 16'($urandom));
        issue_op(OP_ALLOC, '0, '0);
        issue_op(OP_ALLOC, '1, '1);
        repeat (3)
        begin
            h = pick_live();
            issue_op(OP_DESTROY, h.idx, h.ver);
        end
        repeat (4)
            issue_op(OP_ALLOC, '0, '0);
        h = pick_live();
        issue_op(OP_CHECK, h.idx, h.ver);
        issue_op(OP_CHECK, 10'h3FF, 16'hFFFF);
        wait_results_drained();
    endtask

    initial
    begin
        int waited;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_slot_reuse();
        test_random_traffic(600);
        test_fill_to_full();
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
